[rtl/scancode_to_ascii_fifo_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scancode to ASCII FIFO
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SC2A_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle");

// Consequent must hold in the cycle after the antecedent
`define SC2A_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`endif

[rtl/sc2a_pkg.sv]
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared constants and types for the scancode to ASCII FIFO.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  // Character buffer geometry; one slot always stays free
  localparam int unsigned BufDepth = 256;
  localparam int unsigned PtrW     = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam int unsigned CharW    = 7;

  // Result codes
  typedef enum logic [2:0] {
    OUT_STORED     = 3'd0,
    OUT_IGNORED    = 3'd1,
    OUT_DROPPED    = 3'd2,
    OUT_READ_OK    = 3'd3,
    OUT_READ_EMPTY = 3'd4
  } outcome_e;

  // Operation codes
  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Key map lookup result
  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] ch;
  } key_t;

endpackage

[rtl/sc2a_ram.sv]
// ----------------------------------------------------------------------------
// sc2a_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sc2a_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(Depth)-1:0]  waddr_i,
  input  logic [Width-1:0]          wdata_i,
  input  logic                      re_i,
  input  logic [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sc2a_keymap.sv]
// ----------------------------------------------------------------------------
// sc2a_keymap
// Set 1 make code to unshifted US ASCII lookup.
// ----------------------------------------------------------------------------
module sc2a_keymap (
  input  logic [7:0]     scan_byte_i,
  output sc2a_pkg::key_t key_o
);

  logic [sc2a_pkg::CharW-1:0] ch;

  // Map make codes; break codes, codes past the map, codes 0 and 1 (escape) and modifier keys give zero
  always_comb begin
    case (scan_byte_i)
      8'd2:    ch = 7'h31;
      8'd3:    ch = 7'h32;
      8'd4:    ch = 7'h33;
      8'd5:    ch = 7'h34;
      8'd6:    ch = 7'h35;
      8'd7:    ch = 7'h36;
      8'd8:    ch = 7'h37;
      8'd9:    ch = 7'h38;
      8'd10:   ch = 7'h39;
      8'd11:   ch = 7'h30;
      8'd12:   ch = 7'h2D;
      8'd13:   ch = 7'h3D;
      8'd14:   ch = 7'h08; // backspace
      8'd15:   ch = 7'h09; // tab
      8'd16:   ch = 7'h71;
      8'd17:   ch = 7'h77;
      8'd18:   ch = 7'h65;
      8'd19:   ch = 7'h72;
      8'd20:   ch = 7'h74;
      8'd21:   ch = 7'h79;
      8'd22:   ch = 7'h75;
      8'd23:   ch = 7'h69;
      8'd24:   ch = 7'h6F;
      8'd25:   ch = 7'h70;
      8'd26:   ch = 7'h5B;
      8'd27:   ch = 7'h5D;
      8'd28:   ch = 7'h0A; // enter
      8'd30:   ch = 7'h61;
      8'd31:   ch = 7'h73;
      8'd32:   ch = 7'h64;
      8'd33:   ch = 7'h66;
      8'd34:   ch = 7'h67;
      8'd35:   ch = 7'h68;
      8'd36:   ch = 7'h6A;
      8'd37:   ch = 7'h6B;
      8'd38:   ch = 7'h6C;
      8'd39:   ch = 7'h3B;
      8'd40:   ch = 7'h27;
      8'd41:   ch = 7'h60;
      8'd43:   ch = 7'h5C;
      8'd44:   ch = 7'h7A;
      8'd45:   ch = 7'h78;
      8'd46:   ch = 7'h63;
      8'd47:   ch = 7'h76;
      8'd48:   ch = 7'h62;
      8'd49:   ch = 7'h6E;
      8'd50:   ch = 7'h6D;
      8'd51:   ch = 7'h2C;
      8'd52:   ch = 7'h2E;
      8'd53:   ch = 7'h2F;
      8'd55:   ch = 7'h2A;
      8'd57:   ch = 7'h20; // space
      default: ch = '0;
    endcase
  end

  assign key_o.hit = (ch != '0);
  assign key_o.ch  = ch;

endmodule

[rtl/scancode_to_ascii_fifo.sv]
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// Set 1 scancode decoder feeding a circular character buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation_i / scan_byte_i with start_i high; the
//   word is taken at any rising edge where start_i is high and busy_o is low.
//   busy_o stays low, so one word may be taken every cycle.
//   operation_i low pushes the decoded make code, high pops one character.
//   Result channel: done_o is high for exactly one cycle, the cycle after the
//   word was taken, with outcome_o and char_code_o valid in that cycle.
//   Throughput is one word per cycle; the pointers update at the taking edge
//   and the character store read is registered in the RAM, which forms the
//   result register for char_code_o.
//   The buffer holds up to BufDepth-1 characters; a push into a full buffer
//   is dropped and reported.
//   Reset empties the buffer (both pointers cleared) and drops any pending
//   result; no clearing pass is needed. The receiver cannot stall: every
//   result must be taken in its strobe cycle.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       operation_i,
  input  logic [7:0] scan_byte_i,
  output logic       done_o,
  output logic [2:0] outcome_o,
  output logic [6:0] char_code_o
);

  localparam logic [sc2a_pkg::PtrW-1:0] LastSlot = sc2a_pkg::PtrW'(sc2a_pkg::BufDepth - 1);

  sc2a_pkg::key_t              key;
  sc2a_pkg::outcome_e          outcome_d, outcome_q;
  logic [sc2a_pkg::PtrW-1:0]   wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [sc2a_pkg::PtrW-1:0]   wr_next, rd_next;
  logic [sc2a_pkg::CharW-1:0]  rdata;
  logic                        accept, empty, full, push_en, pop_en;
  logic                        done_d, done_q;

  // Decode the incoming byte
  sc2a_keymap u_keymap (
    .scan_byte_i (scan_byte_i),
    .key_o       (key)
  );

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Wrap the pointers at the buffer end
  assign wr_next = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
  assign empty   = (wr_ptr_q == rd_ptr_q);
  assign full    = (wr_next == rd_ptr_q);

  // Decide the outcome of the word and the pointer moves
  always_comb begin
    push_en   = 1'b0;
    pop_en    = 1'b0;
    outcome_d = sc2a_pkg::OUT_IGNORED;
    if (operation_i == sc2a_pkg::OP_READ) begin
      if (empty) begin
        outcome_d = sc2a_pkg::OUT_READ_EMPTY;
      end else begin
        outcome_d = sc2a_pkg::OUT_READ_OK;
        pop_en    = accept;
      end
    end else if (key.hit) begin
      if (full) begin
        outcome_d = sc2a_pkg::OUT_DROPPED;
      end else begin
        outcome_d = sc2a_pkg::OUT_STORED;
        push_en   = accept;
      end
    end
    wr_ptr_d = push_en ? wr_next : wr_ptr_q;
    rd_ptr_d = pop_en ? rd_next : rd_ptr_q;
    done_d   = accept;
  end

  // Hold pointers and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      done_q    <= 1'b0;
      outcome_q <= sc2a_pkg::OUT_STORED;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      done_q   <= done_d;
      if (accept) begin
        outcome_q <= outcome_d;
      end
    end
  end

  // Character store
  sc2a_ram #(
    .Width (sc2a_pkg::CharW),
    .Depth (sc2a_pkg::BufDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (wr_ptr_q),
    .wdata_i (key.ch),
    .re_i    (pop_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // Present the result word
  assign done_o      = done_q;
  assign outcome_o   = outcome_q;
  assign char_code_o = (outcome_q == sc2a_pkg::OUT_READ_OK) ? rdata : '0;

endmodule

[rtl/sc2a_checker.sv]
// ----------------------------------------------------------------------------
// sc2a_checker
// Port level checks for the scancode to ASCII FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_fifo_assert.svh"

module sc2a_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       operation_i,
  input logic       done_o,
  input logic [2:0] outcome_o,
  input logic [6:0] char_code_o
);

  // Every taken word gives exactly one result in the next cycle
  `SC2A_ASSERT_NEXT(a_result_follows, start_i && !busy_o, done_o)
  `SC2A_ASSERT_NEXT(a_no_spurious_result, !(start_i && !busy_o), !done_o)

  // A read gives a read outcome, a scancode never does
  `SC2A_ASSERT_NEXT(a_read_outcome,
                    start_i && !busy_o && operation_i == sc2a_pkg::OP_READ,
                    outcome_o == sc2a_pkg::OUT_READ_OK ||
                    outcome_o == sc2a_pkg::OUT_READ_EMPTY)

  // Character is zero unless a read succeeded
  `SC2A_ASSERT_SAME(a_char_zero, done_o && outcome_o != sc2a_pkg::OUT_READ_OK, char_code_o == '0)

endmodule

bind scancode_to_ascii_fifo sc2a_checker u_sc2a_checker (.*);

[test/scancode_to_ascii_fifo_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_tb
// Drives scancode and read words into the character FIFO with random gaps and
// checks every result against a behavioural model of the key map and buffer.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_tb;

  localparam int unsigned ItemTarget    = 1250;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 4;

  // Key map rows, first character in the top byte
  localparam logic [8*12-1:0] DigitRow = "1234567890-=";
  localparam logic [8*12-1:0] TopRow   = "qwertyuiop[]";
  localparam logic [8*12-1:0] HomeRow  = {"asdfghjkl;'", 8'h60};
  localparam logic [8*11-1:0] LowRow   = "\\zxcvbnm,./";
  localparam logic [7:0]      ChBackspace = 8'h08;
  localparam logic [7:0]      ChTab       = 8'h09;
  localparam logic [7:0]      ChNewline   = 8'h0A;
  localparam logic [7:0]      ChSpace     = 8'h20;
  localparam logic [7:0]      ChStar      = 8'h2A;

  typedef struct packed {
    sc2a_pkg::op_e op;
    logic [7:0]    scan;
    logic          drain;
  } scan_word_t;

  typedef struct packed {
    sc2a_pkg::outcome_e outcome;
    logic [6:0]         ch;
  } fifo_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start_i     = 1'b0;
  logic       operation_i = 1'b0;
  logic [7:0] scan_byte_i = 8'h00;
  logic       busy_o;
  logic       done_o;
  logic [2:0] outcome_o;
  logic [6:0] char_code_o;

  scan_word_t   pending_words[$];
  fifo_result_t expected_results[$];

  // Model state of the character buffer
  logic [6:0]  char_mem [sc2a_pkg::BufDepth];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;

  int unsigned mismatches   = 0;
  int unsigned queued_words = 0;
  int unsigned taken_words  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned gap_left     = 0;
  int unsigned burst_left   = 0;
  logic        word_taken   = 1'b0;

  scancode_to_ascii_fifo dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .scan_byte_i (scan_byte_i),
    .done_o      (done_o),
    .outcome_o   (outcome_o),
    .char_code_o (char_code_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Unshifted character of a make code, zero when the code maps to nothing
  function automatic logic [6:0] key_char(input logic [7:0] code);
    int unsigned i;
    logic [7:0]  c;
    i = code;
    c = 8'h00;
    if (i >= 2 && i <= 13) c = DigitRow[8*(13-i) +: 8];
    else if (i >= 16 && i <= 27) c = TopRow[8*(27-i) +: 8];
    else if (i >= 30 && i <= 41) c = HomeRow[8*(41-i) +: 8];
    else if (i >= 43 && i <= 53) c = LowRow[8*(53-i) +: 8];
    else if (i == 14) c = ChBackspace;
    else if (i == 15) c = ChTab;
    else if (i == 28) c = ChNewline;
    else if (i == 55) c = ChStar;
    else if (i == 57) c = ChSpace;
    return c[6:0];
  endfunction

  // Advance the model by one word and give the result it should produce
  function automatic fifo_result_t predict_outcome(input sc2a_pkg::op_e op,
                                                   input logic [7:0] code);
    fifo_result_t r;
    logic [6:0]   ch;
    int unsigned  nxt;
    r.ch = '0;
    if (op == sc2a_pkg::OP_SCAN) begin
      ch  = key_char(code);
      nxt = (wr_ptr + 1) % sc2a_pkg::BufDepth;
      if (ch == '0) begin
        r.outcome = sc2a_pkg::OUT_IGNORED;
      end else if (nxt == rd_ptr) begin
        r.outcome = sc2a_pkg::OUT_DROPPED;
      end else begin
        char_mem[wr_ptr] = ch;
        wr_ptr = nxt;
        r.outcome = sc2a_pkg::OUT_STORED;
      end
    end else if (rd_ptr == wr_ptr) begin
      r.outcome = sc2a_pkg::OUT_READ_EMPTY;
    end else begin
      r.ch = char_mem[rd_ptr];
      rd_ptr = (rd_ptr + 1) % sc2a_pkg::BufDepth;
      r.outcome = sc2a_pkg::OUT_READ_OK;
    end
    return r;
  endfunction

  function automatic logic [7:0] mapped_code();
    logic [7:0] code;
    do begin
      code = 8'($urandom_range(57, 2));
    end while (key_char(code) == '0);
    return code;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) begin
      burst_left = $urandom_range(80, 20);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic add_word(input sc2a_pkg::op_e op, input logic [7:0] scan,
                          input logic drain);
    scan_word_t w;
    w.op    = op;
    w.scan  = scan;
    w.drain = drain;
    pending_words.push_back(w);
    queued_words++;
  endtask

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  // Present the next word on the falling edge once the previous one is taken
  always @(negedge clk_i) begin : drive_words
    logic       next_start;
    scan_word_t w;
    next_start = start_i;
    if (!rst_ni) begin
      next_start = 1'b0;
    end else if (!start_i || word_taken) begin
      next_start = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].drain && expected_results.size() != 0)) begin
        w = pending_words.pop_front();
        operation_i <= w.op;
        scan_byte_i <= w.scan;
        next_start = 1'b1;
        gap_left = pick_gap();
      end
    end
    start_i <= next_start;
  end

  // Check results first, then log the word taken at this edge
  always @(posedge clk_i) begin : watch_results
    fifo_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, outcome", 0, outcome_o);
        end else begin
          want = expected_results.pop_front();
          if (outcome_o != want.outcome) report_mismatch("outcome", want.outcome, outcome_o);
          if (char_code_o != want.ch) report_mismatch("char_code", want.ch, char_code_o);
        end
      end
      if (start_i && !busy_o) begin
        expected_results.push_back(predict_outcome(sc2a_pkg::op_e'(operation_i),
                                                   scan_byte_i));
        taken_words++;
      end
    end
    word_taken <= rst_ni && start_i && !busy_o;
  end

  // Stop a run that has stopped moving
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned   useful;
    int unsigned   kind;
    int unsigned   len;
    logic          drain;
    sc2a_pkg::op_e op;
    logic [7:0]    code;

    // Directed: empty read, every special code, then drain the buffer
    add_word(sc2a_pkg::OP_READ, 8'hFF, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h00, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h01, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h02, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h0E, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h0F, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h1C, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h2A, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h37, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h39, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h3A, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h7F, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h80, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'hFF, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h0B, 1'b0);
    add_word(sc2a_pkg::OP_SCAN, 8'h35, 1'b0);
    for (int k = 0; k < 9; k++) begin
      add_word(sc2a_pkg::OP_READ, 8'($urandom_range(255)), 1'b0);
    end

    // Fill past full from empty, then read past empty
    for (int k = 0; k < sc2a_pkg::BufDepth + 2; k++) begin
      add_word(sc2a_pkg::OP_SCAN, mapped_code(), k == 0);
    end
    for (int k = 0; k < sc2a_pkg::BufDepth + 1; k++) begin
      add_word(sc2a_pkg::OP_READ, 8'($urandom_range(255)), k == 0);
    end

    // Random groups: mixed traffic, push runs, read runs and noise
    useful = queued_words;
    while (useful < ItemTarget) begin
      kind  = $urandom_range(9);
      len   = $urandom_range(40, 1);
      drain = ($urandom_range(9) == 0);
      for (int k = 0; k < len; k++) begin
        if (kind <= 3) begin
          op = ($urandom_range(99) < 55) ? sc2a_pkg::OP_SCAN : sc2a_pkg::OP_READ;
        end else if (kind <= 6) begin
          op = sc2a_pkg::OP_SCAN;
        end else if (kind <= 8) begin
          op = sc2a_pkg::OP_READ;
        end else begin
          op = sc2a_pkg::op_e'($urandom_range(1));
        end
        if (op == sc2a_pkg::OP_SCAN && kind != 9 && $urandom_range(99) < 85) begin
          code = mapped_code();
        end else begin
          code = 8'($urandom_range(255));
        end
        add_word(op, code, drain && k == 0);
        if (op == sc2a_pkg::OP_READ || key_char(code) != '0) useful++;
      end
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to be taken and every result to come back
    while (taken_words != queued_words || expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (expected_results.size() != 0) report_mismatch("results left over", 0,
                                                      expected_results.size());
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
